FILE: rtl/rsfh_pkg.sv
// ----------------------------------------------------------------------------
// rsfh_pkg: shared types and constants for the ray/segment first-hit core
// Coordinate width, derived datapath widths, payload structs, FSM codes.
// ----------------------------------------------------------------------------
package rsfh_pkg;

    // coordinate width of registers and segment endpoints
    localparam int COORD_BITS = 24;
    // coordinate differences
    localparam int DW   = COORD_BITS + 1;
    // exact fraction state (numerator, denominator)
    localparam int SW   = 2 * COORD_BITS + 4;
    // half of a state word, one partial product operand
    localparam int HW   = SW / 2;
    // signed multiplier operand width
    localparam int MW   = HW + 1;
    // accumulator width, holds a full signed state x state product
    localparam int AW   = 2 * SW + 2;
    // magnitude of a direction x numerator product, the dividend
    localparam int PW   = DW + SW;
    // divider bit counter
    localparam int DCW  = $clog2(PW + 1);
    // micro step counter
    localparam int STW  = 4;
    // register file address and data
    localparam int PAW  = 4;
    localparam int PDW  = 32;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] seg_ax;
        logic signed [COORD_BITS-1:0] seg_ay;
        logic signed [COORD_BITS-1:0] seg_bx;
        logic signed [COORD_BITS-1:0] seg_by;
        logic                         last_segment;
    } t_seg;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] hit_x;
        logic signed [COORD_BITS-1:0] hit_y;
    } t_hit;

    typedef enum logic [1:0] {
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_TOWARD_X,
        REG_TOWARD_Y
    } t_reg_idx;

    // partial product placement in the accumulator
    typedef enum logic [1:0] {
        SH_0,
        SH_1,
        SH_2
    } t_shift;

    typedef struct packed {
        logic   en;
        logic   clr;
        logic   sub;
        t_shift sh;
    } t_mac_op;

    typedef struct packed {
        logic busy;
        logic done;
        logic inexact;
    } t_div_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CROSS,
        ST_DOT,
        ST_RES,
        ST_CMP,
        ST_FIN,
        ST_MULX,
        ST_DIVX,
        ST_MULY,
        ST_DIVY,
        ST_OUT
    } t_state;

    // signed difference to multiplier operand
    function automatic logic signed [MW-1:0] sx_op(input logic signed [DW-1:0] v);
        return MW'(v);
    endfunction

    // unsigned half word to multiplier operand
    function automatic logic signed [MW-1:0] zx_op(input logic [HW-1:0] v);
        return MW'(v);
    endfunction

endpackage

FILE: rtl/rsfh_mac.sv
// ----------------------------------------------------------------------------
// rsfh_mac: shared multiply-accumulate unit
// One signed multiply per cycle when enabled, placed at 0, HW or 2*HW bits and
// added to or subtracted from a wide accumulator.
// ----------------------------------------------------------------------------
module rsfh_mac (
    input  logic                              i_clk,
    input  rsfh_pkg::t_mac_op                 i_op,
    input  logic signed [rsfh_pkg::MW-1:0]    i_a,
    input  logic signed [rsfh_pkg::MW-1:0]    i_b,
    output logic signed [rsfh_pkg::AW-1:0]    o_acc
);
    import rsfh_pkg::*;

    logic signed [AW-1:0]   r_acc;
    logic signed [AW-1:0]   n_acc;
    logic signed [2*MW-1:0] prod;
    logic signed [AW-1:0]   prod_ext;
    logic signed [AW-1:0]   prod_sh;
    logic signed [AW-1:0]   base;

    // product, placed by the shift code
    always_comb begin
        prod     = i_a * i_b;
        prod_ext = AW'(prod);
        case (i_op.sh)
            SH_0:    prod_sh = prod_ext;
            SH_1:    prod_sh = prod_ext <<< HW;
            SH_2:    prod_sh = prod_ext <<< (2 * HW);
            default: prod_sh = prod_ext;
        endcase
        base  = i_op.clr ? '0 : r_acc;
        n_acc = i_op.sub ? (base - prod_sh) : (base + prod_sh);
    end

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: rtl/rsfh_div.sv
// ----------------------------------------------------------------------------
// rsfh_div: bit-serial restoring divider
// One quotient bit per cycle while busy; keeps the low COORD_BITS of the
// quotient and flags a nonzero remainder.
// ----------------------------------------------------------------------------
module rsfh_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [rsfh_pkg::PW-1:0]              i_num,
    input  logic [rsfh_pkg::SW-1:0]              i_den,
    output rsfh_pkg::t_div_stat                  o_stat,
    output logic [rsfh_pkg::COORD_BITS-1:0]      o_quo
);
    import rsfh_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DCW-1:0]        r_cnt;
    logic [PW-1:0]         r_num;
    logic [SW-1:0]         r_den;
    logic [SW-1:0]         r_rem;
    logic [COORD_BITS-1:0] r_quo;
    logic [SW:0]           trial;
    logic                  qbit;
    logic [SW:0]           diff;

    // one restoring step
    always_comb begin
        trial = {r_rem, r_num[PW-1]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCW'(PW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCW'(1);
                if (r_cnt == DCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[PW-2:0], 1'b0};
            r_rem <= qbit ? diff[SW-1:0] : trial[SW-1:0];
            r_quo <= {r_quo[COORD_BITS-2:0], qbit};
        end
    end

    assign o_stat.busy    = r_busy;
    assign o_stat.done    = r_done;
    assign o_stat.inexact = (r_rem != '0);
    assign o_quo          = r_quo;

endmodule

FILE: rtl/ray_segment_first_hit_core.sv
// ----------------------------------------------------------------------------
// ray_segment_first_hit_core: nearest ray/segment crossing over a segment set
// Sequencer around one shared multiply-accumulate unit and a serial divider.
// ----------------------------------------------------------------------------
// Usage: the ray is to be set through the register port (origin, toward point)
// while the core is idle; the core itself does not enforce this. Each segment
// transfer holds the input stalled while the three cross products are formed
// and the item is resolved and closed, and further while three dot products
// follow when the segment is collinear with the ray and while a candidate is
// compared against the kept hit; all of this is paced by the single 27x27
// multiply-accumulate unit, which does one partial product per cycle. A
// segment marked last adds, if a hit is kept, the two exact floor divisions,
// done one quotient bit per cycle, before the result is offered. The input is
// stalled for the whole time an item is in work; a waiting result sits in an
// output register and only holds the core back when the next result is ready.
// ----------------------------------------------------------------------------
module ray_segment_first_hit_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // segment input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rsfh_pkg::t_seg                i_in_data,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rsfh_pkg::t_hit                o_out_data,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsfh_pkg::PAW-1:0]      paddr,
    input  logic [rsfh_pkg::PDW-1:0]      pwdata,
    output logic [rsfh_pkg::PDW-1:0]      prdata,
    output logic                          pready
);
    import rsfh_pkg::*;

    localparam int CB = COORD_BITS;

    // configuration
    logic signed [CB-1:0] r_ox, r_oy, r_tx, r_ty;
    logic                 cfg_wr;
    t_reg_idx             cfg_idx;

    // per item differences
    logic signed [DW-1:0] dx, dy;
    logic signed [DW-1:0] r_wx, r_wy, r_ex, r_ey, r_vx, r_vy;
    logic                 r_last;
    logic                 in_xfer;

    // sequencer
    t_state               r_state, n_state;
    logic [STW-1:0]       r_step, n_step;
    logic signed [SW-1:0] r_den, n_den, r_tn, n_tn, r_sa, n_sa, r_sb, n_sb;
    logic [SW-1:0]        r_cn, n_cn, r_cd, n_cd;
    logic                 r_cand, n_cand;
    logic [SW-1:0]        r_bn, n_bn, r_bd, n_bd;
    logic                 r_have, n_have;
    logic                 r_pneg, n_pneg;
    logic [CB-1:0]        r_hx, n_hx, r_hy, n_hy;
    logic                 r_ovalid, n_ovalid;
    t_hit                 r_odata, n_odata;

    // shared units
    t_mac_op              mac_op;
    logic signed [MW-1:0] mac_a, mac_b;
    logic signed [AW-1:0] acc;
    logic signed [SW-1:0] acc_s;
    logic signed [AW-1:0] acc_abs;
    logic                 div_start;
    t_div_stat            div_stat;
    logic [CB-1:0]        quo;
    logic [CB-1:0]        floor_f;
    logic [CB-1:0]        coord;

    // decision helpers
    logic signed [SW-1:0] den_n, tn_n, un_n, lo, hi;
    logic                 ray_zero;

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[PAW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0;
            r_oy <= '0;
            r_tx <= CB'(1);
            r_ty <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ORIGIN_X: r_ox <= pwdata[CB-1:0];
                REG_ORIGIN_Y: r_oy <= pwdata[CB-1:0];
                REG_TOWARD_X: r_tx <= pwdata[CB-1:0];
                REG_TOWARD_Y: r_ty <= pwdata[CB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ORIGIN_X: prdata = PDW'($unsigned(r_ox));
            REG_ORIGIN_Y: prdata = PDW'($unsigned(r_oy));
            REG_TOWARD_X: prdata = PDW'($unsigned(r_tx));
            REG_TOWARD_Y: prdata = PDW'($unsigned(r_ty));
            default:      prdata = '0;
        endcase
    end

    // ray direction
    assign dx       = DW'(r_tx) - DW'(r_ox);
    assign dy       = DW'(r_ty) - DW'(r_oy);
    assign ray_zero = (dx == '0) && (dy == '0);

    // ------------------------------------------------------------------
    // segment capture
    // ------------------------------------------------------------------
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_wx   <= DW'(i_in_data.seg_ax) - DW'(r_ox);
            r_wy   <= DW'(i_in_data.seg_ay) - DW'(r_oy);
            r_ex   <= DW'(i_in_data.seg_bx) - DW'(i_in_data.seg_ax);
            r_ey   <= DW'(i_in_data.seg_by) - DW'(i_in_data.seg_ay);
            r_vx   <= DW'(i_in_data.seg_bx) - DW'(r_ox);
            r_vy   <= DW'(i_in_data.seg_by) - DW'(r_oy);
            r_last <= i_in_data.last_segment;
        end
    end

    // ------------------------------------------------------------------
    // shared units
    // ------------------------------------------------------------------
    rsfh_mac u_mac (
        .i_clk (i_clk),
        .i_op  (mac_op),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (acc)
    );

    assign acc_s   = acc[SW-1:0];
    assign acc_abs = acc[AW-1] ? -acc : acc;

    rsfh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (acc_abs[PW-1:0]),
        .i_den   (r_bd),
        .o_stat  (div_stat),
        .o_quo   (quo)
    );

    // floor of the signed quotient, then offset by the origin
    always_comb begin
        floor_f = r_pneg ? CB'(-(quo + CB'(div_stat.inexact))) : quo;
        coord   = (r_state == ST_DIVY) ? (CB'(r_oy) + floor_f) : (CB'(r_ox) + floor_f);
    end

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_have   <= 1'b0;
            r_bn     <= '0;
            r_bd     <= SW'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_have   <= n_have;
            r_bn     <= n_bn;
            r_bd     <= n_bd;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den   <= n_den;
        r_tn    <= n_tn;
        r_sa    <= n_sa;
        r_sb    <= n_sb;
        r_cn    <= n_cn;
        r_cd    <= n_cd;
        r_cand  <= n_cand;
        r_pneg  <= n_pneg;
        r_hx    <= n_hx;
        r_hy    <= n_hy;
        r_odata <= n_odata;
    end

    // ------------------------------------------------------------------
    // sequencer: next state, unit operands
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_den     = r_den;
        n_tn      = r_tn;
        n_sa      = r_sa;
        n_sb      = r_sb;
        n_cn      = r_cn;
        n_cd      = r_cd;
        n_cand    = r_cand;
        n_bn      = r_bn;
        n_bd      = r_bd;
        n_have    = r_have;
        n_pneg    = r_pneg;
        n_hx      = r_hx;
        n_hy      = r_hy;
        n_odata   = r_odata;
        n_ovalid  = r_ovalid && i_out_stall;
        mac_op    = '0;
        mac_a     = '0;
        mac_b     = '0;
        div_start = 1'b0;

        // sign-normalized cross products
        den_n = r_den[SW-1] ? -r_den : r_den;
        tn_n  = r_den[SW-1] ? -r_tn : r_tn;
        un_n  = r_den[SW-1] ? -acc_s : acc_s;
        // ordered endpoint projections
        lo    = (r_sb < r_sa) ? r_sb : r_sa;
        hi    = (r_sb < r_sa) ? r_sa : r_sb;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_CROSS;
                    n_step  = '0;
                end
            end

            // den = d x e, tn = w x e, un = w x d
            ST_CROSS: begin
                n_step = r_step + STW'(1);
                case (r_step)
                    STW'(0): begin
                        mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_0};
                        mac_a  = sx_op(dx);
                        mac_b  = sx_op(r_ey);
                    end
                    STW'(1): begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b1, sh: SH_0};
                        mac_a  = sx_op(dy);
                        mac_b  = sx_op(r_ex);
                    end
                    STW'(2): begin
                        n_den  = acc_s;
                        mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_0};
                        mac_a  = sx_op(r_wx);
                        mac_b  = sx_op(r_ey);
                    end
                    STW'(3): begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b1, sh: SH_0};
                        mac_a  = sx_op(r_wy);
                        mac_b  = sx_op(r_ex);
                    end
                    STW'(4): begin
                        n_tn   = acc_s;
                        mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_0};
                        mac_a  = sx_op(r_wx);
                        mac_b  = sx_op(dy);
                    end
                    STW'(5): begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b1, sh: SH_0};
                        mac_a  = sx_op(r_wy);
                        mac_b  = sx_op(dx);
                    end
                    default: begin
                        // accumulator holds un
                        n_step  = '0;
                        n_cand  = 1'b0;
                        n_state = ST_RES;
                        if (ray_zero) begin
                            n_cand = 1'b0;
                        end else if (r_den != '0) begin
                            n_cand = !tn_n[SW-1] && !un_n[SW-1] && (un_n <= den_n);
                            n_cn   = tn_n;
                            n_cd   = den_n;
                        end else if (acc_s == '0) begin
                            n_state = ST_DOT;
                        end
                    end
                endcase
            end

            // collinear: sa = w.d, sb = v.d, then d.d
            ST_DOT: begin
                n_step = r_step + STW'(1);
                case (r_step)
                    STW'(0): begin
                        mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_0};
                        mac_a  = sx_op(r_wx);
                        mac_b  = sx_op(dx);
                    end
                    STW'(1): begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_0};
                        mac_a  = sx_op(r_wy);
                        mac_b  = sx_op(dy);
                    end
                    STW'(2): begin
                        n_sa   = acc_s;
                        mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_0};
                        mac_a  = sx_op(r_vx);
                        mac_b  = sx_op(dx);
                    end
                    STW'(3): begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_0};
                        mac_a  = sx_op(r_vy);
                        mac_b  = sx_op(dy);
                    end
                    STW'(4): begin
                        n_sb   = acc_s;
                        mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_0};
                        mac_a  = sx_op(dx);
                        mac_b  = sx_op(dx);
                    end
                    STW'(5): begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_0};
                        mac_a  = sx_op(dy);
                        mac_b  = sx_op(dy);
                    end
                    default: begin
                        // accumulator holds d.d
                        n_step  = '0;
                        n_state = ST_RES;
                        n_cand  = !hi[SW-1];
                        if (!lo[SW-1] && (lo != '0)) begin
                            n_cn = lo;
                            n_cd = acc_s;
                        end else begin
                            // segment covers the origin
                            n_cn = '0;
                            n_cd = SW'(1);
                        end
                    end
                endcase
            end

            ST_RES: begin
                n_step = '0;
                if (r_cand && r_have) begin
                    n_state = ST_CMP;
                end else begin
                    if (r_cand) begin
                        n_bn   = r_cn;
                        n_bd   = r_cd;
                        n_have = 1'b1;
                    end
                    n_state = ST_FIN;
                end
            end

            // cn*bd - bn*cd from half-word partial products
            ST_CMP: begin
                n_step = r_step + STW'(1);
                case (r_step)
                    STW'(0): begin
                        mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_0};
                        mac_a  = zx_op(r_cn[HW-1:0]);
                        mac_b  = zx_op(r_bd[HW-1:0]);
                    end
                    STW'(1): begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_1};
                        mac_a  = zx_op(r_cn[HW-1:0]);
                        mac_b  = zx_op(r_bd[SW-1:HW]);
                    end
                    STW'(2): begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_1};
                        mac_a  = zx_op(r_cn[SW-1:HW]);
                        mac_b  = zx_op(r_bd[HW-1:0]);
                    end
                    STW'(3): begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_2};
                        mac_a  = zx_op(r_cn[SW-1:HW]);
                        mac_b  = zx_op(r_bd[SW-1:HW]);
                    end
                    STW'(4): begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b1, sh: SH_0};
                        mac_a  = zx_op(r_bn[HW-1:0]);
                        mac_b  = zx_op(r_cd[HW-1:0]);
                    end
                    STW'(5): begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b1, sh: SH_1};
                        mac_a  = zx_op(r_bn[HW-1:0]);
                        mac_b  = zx_op(r_cd[SW-1:HW]);
                    end
                    STW'(6): begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b1, sh: SH_1};
                        mac_a  = zx_op(r_bn[SW-1:HW]);
                        mac_b  = zx_op(r_cd[HW-1:0]);
                    end
                    STW'(7): begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b1, sh: SH_2};
                        mac_a  = zx_op(r_bn[SW-1:HW]);
                        mac_b  = zx_op(r_cd[SW-1:HW]);
                    end
                    default: begin
                        // strictly nearer replaces the kept hit
                        n_step  = '0;
                        n_state = ST_FIN;
                        if (acc[AW-1]) begin
                            n_bn = r_cn;
                            n_bd = r_cd;
                        end
                    end
                endcase
            end

            ST_FIN: begin
                n_step = '0;
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (r_have) begin
                    n_state = ST_MULX;
                end else begin
                    n_hx    = '0;
                    n_hy    = '0;
                    n_state = ST_OUT;
                end
            end

            // d * bn, then floor divide by bd
            ST_MULX, ST_MULY: begin
                n_step = r_step + STW'(1);
                case (r_step)
                    STW'(0): begin
                        mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_0};
                        mac_a  = sx_op((r_state == ST_MULY) ? dy : dx);
                        mac_b  = zx_op(r_bn[HW-1:0]);
                    end
                    STW'(1): begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_1};
                        mac_a  = sx_op((r_state == ST_MULY) ? dy : dx);
                        mac_b  = zx_op(r_bn[SW-1:HW]);
                    end
                    default: begin
                        n_step    = '0;
                        n_pneg    = acc[AW-1];
                        div_start = 1'b1;
                        n_state   = (r_state == ST_MULY) ? ST_DIVY : ST_DIVX;
                    end
                endcase
            end

            ST_DIVX: begin
                if (div_stat.done) begin
                    n_hx    = coord;
                    n_step  = '0;
                    n_state = ST_MULY;
                end
            end

            ST_DIVY: begin
                if (div_stat.done) begin
                    n_hy    = coord;
                    n_state = ST_OUT;
                end
            end

            // load the output register, clear the set
            ST_OUT: begin
                if (!n_ovalid) begin
                    n_ovalid      = 1'b1;
                    n_odata.hit   = r_have;
                    n_odata.hit_x = r_hx;
                    n_odata.hit_y = r_hy;
                    n_have        = 1'b0;
                    n_bn          = '0;
                    n_bd          = SW'(1);
                    n_state       = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_bd != '0))
        else $error("kept hit has a zero denominator");

    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == ST_DIVX || r_state == ST_DIVY))
        else $error("divider busy outside a divide state");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_CROSS && r_step == '0))
        else $error("accepted segment did not start the cross products");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == ST_OUT) && r_state == ST_IDLE) |-> o_out_valid)
        else $error("result state left without loading the output");

endmodule
